// ----- rtl/qme_pkg.sv -----
package qme_pkg;

   typedef enum logic [4:0] {
      OP_PUSH_IMM  = 5'd0,
      OP_ADD       = 5'd1,
      OP_SUB       = 5'd2,
      OP_MUL       = 5'd3,
      OP_DIV       = 5'd4,
      OP_MOD       = 5'd5,
      OP_POP_REG   = 5'd6,
      OP_PUSH_REG  = 5'd7,
      OP_PRINT_Q   = 5'd8,
      OP_PRINT_R   = 5'd9,
      OP_CHAR_Q    = 5'd10,
      OP_CHAR_R    = 5'd11,
      OP_LABEL     = 5'd12,
      OP_JUMP      = 5'd13,
      OP_JZ        = 5'd14,
      OP_JEQ       = 5'd15,
      OP_JGT       = 5'd16,
      OP_QUIT      = 5'd17
   } op_type;

   typedef enum logic [1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_UNDERFLOW = 2'd1,
      FAULT_OVERFLOW  = 2'd2
   } fault_type;

   localparam int unsigned WORD_W   = 16;
   localparam int unsigned REG_IDX_W = 5;
   localparam int unsigned NUM_REGS_C = 26;
   localparam int unsigned TARGET_W = 10;

   // Divider control handed from the sequencer to the divide unit.
   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] quotient;
      logic [WORD_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ----- rtl/qme_divider.sv -----
module qme_divider
   import qme_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W:0]   rem_ff, rem_in;
   logic [WORD_W-1:0] dvs_ff, dvs_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WORD_W:0]   trial;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[WORD_W-1:0], quo_ff[WORD_W-1]};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = 5'(WORD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in    = trial - {1'b0, dvs_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff[WORD_W-1:0];

endmodule

// ----- rtl/qme_queue_mem.sv -----
module qme_queue_mem
   import qme_pkg::*;
#(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned ADDR_W = 8
)(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/queue_machine_execute.sv -----
// Sequence: an accepted request passes through decode, one pop per queue operand (a pop
// state, then a read-wait state when the queue is not empty), execute, a wait on the
// bit-serial divider for divide and remainder with a nonzero divisor, a push for pushed
// results, and a response state; once halted, decode goes straight to the response.
// One request in flight: the next is accepted only after the response has been taken.
// Reset: synchronous; clears state, response valid, queue pointers, count, registers, halt.
module queue_machine_execute
   import qme_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 256,
   parameter int unsigned PROG_DEPTH  = 1024
)(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [4:0]                    req_mode,
   input  logic [WORD_W-1:0]             req_immediate,
   input  logic [REG_IDX_W-1:0]          req_reg_first,
   input  logic [REG_IDX_W-1:0]          req_reg_second,
   input  logic [$clog2(PROG_DEPTH)-1:0] req_jump_target,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_print_valid,
   output logic                          rsp_print_is_char,
   output logic [WORD_W-1:0]             rsp_print_value,
   output logic                          rsp_branch_taken,
   output logic [$clog2(PROG_DEPTH)-1:0] rsp_branch_target,
   output logic                          rsp_halted,
   output logic [1:0]                    rsp_fault
);

   localparam int unsigned QA_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned QC_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned PT_W  = $clog2(PROG_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_POP1, ST_WAIT1, ST_POP2, ST_WAIT2,
      ST_EXEC, ST_DIVWAIT, ST_PUSH, ST_RESP
   } state_type;

   state_type           state_ff;
   logic [4:0]          mode_ff;
   logic [WORD_W-1:0]   imm_ff;
   logic [REG_IDX_W-1:0] ra_ff, rb_ff;
   logic [PT_W-1:0]     tgt_ff;
   logic [WORD_W-1:0]   x_ff, y_ff, res_ff;
   logic [QA_W-1:0]     head_ff, tail_ff;
   logic [QC_W-1:0]     count_ff;
   logic                halt_ff;
   logic [WORD_W-1:0]   regs_ff [NUM_REGS_C];
   logic                rsp_valid_ff;
   logic                pv_ff, pc_ff, tk_ff;
   logic [WORD_W-1:0]   pval_ff;
   logic [PT_W-1:0]     btgt_ff;
   logic [1:0]          fault_ff;
   logic                do_push_ff;
   logic [WORD_W-1:0]   push_val_ff;

   logic                q_wr_en;
   logic [WORD_W-1:0]   q_rd_data;
   div_req_type         div_req;
   div_rsp_type         div_rsp;
   logic [WORD_W-1:0]   rd_a, rd_b, mul_lo;
   logic [31:0]         mul_full;

   qme_queue_mem #(.DEPTH(QUEUE_DEPTH), .ADDR_W(QA_W)) u_queue (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (tail_ff),
      .wr_data (push_val_ff),
      .rd_addr (head_ff),
      .rd_data (q_rd_data)
   );

   qme_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Register reads with out-of-range indexes reading as zero.
   assign rd_a = (ra_ff < REG_IDX_W'(NUM_REGS_C)) ? regs_ff[ra_ff] : '0;
   assign rd_b = (rb_ff < REG_IDX_W'(NUM_REGS_C)) ? regs_ff[rb_ff] : '0;
   assign mul_full = 32'(x_ff) * 32'(y_ff);
   assign mul_lo   = mul_full[WORD_W-1:0];

   assign q_wr_en = (state_ff == ST_PUSH) && do_push_ff &&
                    (count_ff < QC_W'(QUEUE_DEPTH));
   assign div_req.start    = (state_ff == ST_EXEC) &&
                             (mode_ff == OP_DIV || mode_ff == OP_MOD) &&
                             (y_ff != '0);
   assign div_req.dividend = x_ff;
   assign div_req.divisor  = y_ff;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;

   // Sequencer for one instruction.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS_C; i++) regs_ff[i] <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && !req_stall) begin
                  mode_ff    <= req_mode;
                  imm_ff     <= req_immediate;
                  ra_ff      <= req_reg_first;
                  rb_ff      <= req_reg_second;
                  tgt_ff     <= req_jump_target;
                  pv_ff      <= 1'b0;
                  pc_ff      <= 1'b0;
                  pval_ff    <= '0;
                  tk_ff      <= 1'b0;
                  btgt_ff    <= '0;
                  fault_ff   <= FAULT_NONE;
                  x_ff       <= '0;
                  y_ff       <= '0;
                  do_push_ff <= 1'b0;
                  state_ff   <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               if (halt_ff) begin
                  state_ff <= ST_RESP;
               end else if (mode_ff >= OP_ADD && mode_ff <= OP_MOD) begin
                  state_ff <= ST_POP1;
               end else if (mode_ff == OP_POP_REG || mode_ff == OP_PRINT_Q ||
                            mode_ff == OP_CHAR_Q) begin
                  state_ff <= ST_POP1;
               end else begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_POP1, ST_POP2: begin
               // Pop: empty queue yields zero and flags underflow.
               if (count_ff == '0) begin
                  if (fault_ff == FAULT_NONE) fault_ff <= FAULT_UNDERFLOW;
                  state_ff <= (state_ff == ST_POP1 && mode_ff <= OP_MOD) ?
                              ST_POP2 : ST_EXEC;
               end else begin
                  state_ff <= (state_ff == ST_POP1) ? ST_WAIT1 : ST_WAIT2;
               end
            end
            ST_WAIT1: begin
               x_ff     <= q_rd_data;
               head_ff  <= (head_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               count_ff <= count_ff - 1'b1;
               state_ff <= (mode_ff <= OP_MOD) ? ST_POP2 : ST_EXEC;
            end
            ST_WAIT2: begin
               y_ff     <= q_rd_data;
               head_ff  <= (head_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               count_ff <= count_ff - 1'b1;
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               state_ff <= ST_RESP;
               priority case (mode_ff)
                  OP_PUSH_IMM: begin
                     push_val_ff <= imm_ff; do_push_ff <= 1'b1; state_ff <= ST_PUSH;
                  end
                  OP_ADD: begin
                     push_val_ff <= x_ff + y_ff; do_push_ff <= 1'b1; state_ff <= ST_PUSH;
                  end
                  OP_SUB: begin
                     push_val_ff <= x_ff - y_ff; do_push_ff <= 1'b1; state_ff <= ST_PUSH;
                  end
                  OP_MUL: begin
                     push_val_ff <= mul_lo; do_push_ff <= 1'b1; state_ff <= ST_PUSH;
                  end
                  OP_DIV, OP_MOD: begin
                     do_push_ff <= 1'b1;
                     if (y_ff == '0) begin
                        push_val_ff <= '0; state_ff <= ST_PUSH;
                     end else begin
                        state_ff <= ST_DIVWAIT;
                     end
                  end
                  OP_POP_REG: begin
                     if (ra_ff < REG_IDX_W'(NUM_REGS_C)) regs_ff[ra_ff] <= x_ff;
                  end
                  OP_PUSH_REG: begin
                     push_val_ff <= rd_a; do_push_ff <= 1'b1; state_ff <= ST_PUSH;
                  end
                  OP_PRINT_Q: begin pv_ff <= 1'b1; pval_ff <= x_ff; end
                  OP_PRINT_R: begin pv_ff <= 1'b1; pval_ff <= rd_a; end
                  OP_CHAR_Q: begin
                     pv_ff <= 1'b1; pc_ff <= 1'b1; pval_ff <= {8'd0, x_ff[7:0]};
                  end
                  OP_CHAR_R: begin
                     pv_ff <= 1'b1; pc_ff <= 1'b1; pval_ff <= {8'd0, rd_a[7:0]};
                  end
                  OP_JUMP: begin tk_ff <= 1'b1; btgt_ff <= tgt_ff; end
                  OP_JZ: if (rd_a == '0) begin tk_ff <= 1'b1; btgt_ff <= tgt_ff; end
                  OP_JEQ: if (rd_a == rd_b) begin tk_ff <= 1'b1; btgt_ff <= tgt_ff; end
                  OP_JGT: if (rd_a > rd_b) begin tk_ff <= 1'b1; btgt_ff <= tgt_ff; end
                  OP_QUIT: halt_ff <= 1'b1;
                  default: ;
               endcase
            end
            ST_DIVWAIT: begin
               if (div_rsp.done) begin
                  push_val_ff <= (mode_ff == OP_DIV) ? div_rsp.quotient
                                                     : div_rsp.remainder;
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               // Push: full queue drops the value and flags overflow.
               if (q_wr_en) begin
                  tail_ff  <= (tail_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                  count_ff <= count_ff + 1'b1;
               end else if (fault_ff == FAULT_NONE) begin
                  fault_ff <= FAULT_OVERFLOW;
               end
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_print_valid   = pv_ff;
   assign rsp_print_is_char = pc_ff;
   assign rsp_print_value   = pval_ff;
   assign rsp_branch_taken  = tk_ff;
   assign rsp_branch_target = btgt_ff;
   assign rsp_halted        = halt_ff;
   assign rsp_fault         = fault_ff;

   // The fill count never exceeds the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QC_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // A write to the queue always has room.
   assert property (@(posedge clock) disable iff (reset)
      q_wr_en |-> count_ff != QC_W'(QUEUE_DEPTH))
      else $error("queue write while full");

   // Once halted, the machine stays halted until reset.
   assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag dropped");

   // No request is taken while a response is pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall)
      else $error("request accepted with response pending");

endmodule

// ----- tb/queue_machine_checker.sv -----
module queue_machine_checker
   import qme_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [4:0]  req_mode,
   input  logic [15:0] req_immediate,
   input  logic [4:0]  req_reg_first,
   input  logic [4:0]  req_reg_second,
   input  logic [9:0]  req_jump_target,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_print_valid,
   input  logic        rsp_print_is_char,
   input  logic [15:0] rsp_print_value,
   input  logic        rsp_branch_taken,
   input  logic [9:0]  rsp_branch_target,
   input  logic        rsp_halted,
   input  logic [1:0]  rsp_fault,
   output int          error_count,
   output int          pending_count
);

   localparam int QDEPTH = 256;

   typedef struct packed {
      logic        print_valid;
      logic        print_is_char;
      logic [15:0] print_value;
      logic        branch_taken;
      logic [9:0]  branch_target;
      logic        halted;
      logic [1:0]  fault;
   } outcome_type;

   // Shadow machine state.
   logic [15:0] operand_fifo[$];
   logic [15:0] regs[26];
   logic        stopped;
   logic [1:0]  cur_fault;
   outcome_type expected_outcomes[$];

   function automatic logic [15:0] fifo_take();
      if (operand_fifo.size() == 0) begin
         if (cur_fault == FAULT_NONE) cur_fault = FAULT_UNDERFLOW;
         return 16'd0;
      end
      return operand_fifo.pop_front();
   endfunction

   function automatic void fifo_put(logic [15:0] v);
      if (operand_fifo.size() >= QDEPTH) begin
         if (cur_fault == FAULT_NONE) cur_fault = FAULT_OVERFLOW;
      end else begin
         operand_fifo.insert(operand_fifo.size(), v);
      end
   endfunction

   function automatic logic [15:0] reg_value(logic [4:0] idx);
      return (idx < 26) ? regs[idx] : 16'd0;
   endfunction

   // Execute one instruction on the shadow state and return its outcome.
   function automatic outcome_type execute_instr(logic [4:0] mode, logic [15:0] imm,
                                                 logic [4:0] ra, logic [4:0] rb,
                                                 logic [9:0] target);
      outcome_type o;
      logic [15:0] x, y, r;
      o = '0;
      cur_fault = FAULT_NONE;
      if (!stopped) begin
         case (mode)
            OP_PUSH_IMM: fifo_put(imm);
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
               x = fifo_take();
               y = fifo_take();
               case (mode)
                  OP_ADD: r = x + y;
                  OP_SUB: r = x - y;
                  OP_MUL: r = x * y;
                  OP_DIV: r = (y == 0) ? 16'd0 : x / y;
                  default: r = (y == 0) ? 16'd0 : x % y;
               endcase
               fifo_put(r);
            end
            OP_POP_REG: begin
               x = fifo_take();
               if (ra < 26) regs[ra] = x;
            end
            OP_PUSH_REG: fifo_put(reg_value(ra));
            OP_PRINT_Q, OP_PRINT_R, OP_CHAR_Q, OP_CHAR_R: begin
               x = (mode == OP_PRINT_Q || mode == OP_CHAR_Q) ? fifo_take() : reg_value(ra);
               o.print_valid = 1'b1;
               o.print_is_char = (mode >= OP_CHAR_Q);
               o.print_value = o.print_is_char ? {8'd0, x[7:0]} : x;
            end
            OP_JUMP: o.branch_taken = 1'b1;
            OP_JZ:   o.branch_taken = (reg_value(ra) == 0);
            OP_JEQ:  o.branch_taken = (reg_value(ra) == reg_value(rb));
            OP_JGT:  o.branch_taken = (reg_value(ra) > reg_value(rb));
            OP_QUIT: stopped = 1'b1;
            default: ;
         endcase
      end
      o.branch_target = o.branch_taken ? target : 10'd0;
      o.halted = stopped;
      o.fault = cur_fault;
      return o;
   endfunction

   assign pending_count = expected_outcomes.size();

   // Predict on accepted requests and compare accepted responses.
   always @(posedge clock) begin
      outcome_type got, want;
      if (reset) begin
         operand_fifo.delete();
         expected_outcomes.delete();
         foreach (regs[i]) regs[i] = 16'd0;
         stopped = 1'b0;
         error_count = 0;
      end else begin
         if (req_valid && !req_stall)
            expected_outcomes.insert(expected_outcomes.size(),
               execute_instr(req_mode, req_immediate, req_reg_first,
                             req_reg_second, req_jump_target));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_print_valid, rsp_print_is_char, rsp_print_value,
                   rsp_branch_taken, rsp_branch_target, rsp_halted, rsp_fault};
            if (expected_outcomes.size() == 0) begin
               error_count++;
               if (error_count <= 10) $display("Unexpected response %h", got);
            end else begin
               want = expected_outcomes.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("Mismatch (exp/got): pv %b/%b pc %b/%b val %h/%h",
                        want.print_valid, got.print_valid, want.print_is_char,
                        got.print_is_char, want.print_value, got.print_value);
                     $display("   br %b/%b tgt %h/%h hlt %b/%b flt %0d/%0d",
                        want.branch_taken, got.branch_taken, want.branch_target,
                        got.branch_target, want.halted, got.halted, want.fault,
                        got.fault);
                  end
               end
            end
         end
      end
   end

endmodule

// ----- tb/queue_machine_execute_tb.sv -----
module queue_machine_execute_tb
   import qme_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [4:0]  req_mode = '0;
   logic [15:0] req_immediate = '0;
   logic [4:0]  req_reg_first = '0;
   logic [4:0]  req_reg_second = '0;
   logic [9:0]  req_jump_target = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic        rsp_print_valid, rsp_print_is_char, rsp_branch_taken, rsp_halted;
   logic [15:0] rsp_print_value;
   logic [9:0]  rsp_branch_target;
   logic [1:0]  rsp_fault;
   int          error_count, pending_count;
   int          send_idle_pct = 38;
   int          recv_idle_pct = 73;
   int          hold_cycles = 0;
   int          quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   queue_machine_execute dut (.*);

   queue_machine_checker checker_inst (.*);

   // Receiver: random stall, or a long hold when requested.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b1;
      else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Watchdog on cycles with no handshake on either side.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Present one request and hold it until accepted; valid drops at the next
   // call unless another request follows at once.
   task automatic send_request(logic [4:0] mode, logic [15:0] imm, logic [4:0] ra,
                               logic [4:0] rb, logic [9:0] target);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_immediate <= imm;
      req_reg_first <= ra;
      req_reg_second <= rb;
      req_jump_target <= target;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_request();
      int pick;
      logic [4:0] mode, ra;
      pick = $urandom_range(99);
      ra = (pick < 95) ? 5'($urandom_range(25)) : 5'($urandom_range(31));
      if (pick < 30) mode = OP_PUSH_IMM;
      else if (pick < 32) mode = 5'($urandom_range(31));
      else if (pick < 33) mode = (($urandom_range(7) == 0) ? OP_QUIT : OP_LABEL);
      else mode = 5'($urandom_range(OP_ADD, OP_JGT));
      send_request(mode, 16'($urandom()), ra, 5'($urandom_range(31)), 10'($urandom()));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: underflow, extremes, every operation but quit, zero divisor.
      send_request(OP_ADD, 0, 0, 0, 0);
      send_request(OP_PUSH_IMM, 16'hFFFF, 0, 0, 0);
      send_request(OP_PUSH_IMM, 16'hFFFF, 0, 0, 0);
      send_request(OP_MUL, 0, 0, 0, 0);
      send_request(OP_PUSH_IMM, 0, 0, 0, 0);
      send_request(OP_DIV, 0, 0, 0, 0);
      send_request(OP_PUSH_IMM, 7, 0, 0, 0);
      send_request(OP_PUSH_IMM, 0, 0, 0, 0);
      send_request(OP_MOD, 0, 0, 0, 0);
      send_request(OP_PUSH_IMM, 16'h1234, 0, 0, 0);
      send_request(OP_POP_REG, 0, 25, 0, 0);
      send_request(OP_POP_REG, 0, 31, 0, 0);
      send_request(OP_PUSH_REG, 0, 25, 0, 0);
      send_request(OP_PRINT_Q, 0, 0, 0, 0);
      send_request(OP_PRINT_R, 0, 25, 0, 0);
      send_request(OP_CHAR_R, 0, 25, 0, 0);
      send_request(OP_CHAR_Q, 0, 0, 0, 0);
      send_request(OP_SUB, 0, 0, 0, 0);
      send_request(OP_LABEL, 0, 0, 0, 10'h3FF);
      send_request(OP_JUMP, 0, 0, 0, 10'h3FF);
      send_request(OP_JZ, 0, 0, 0, 10'h155);
      send_request(OP_JEQ, 0, 25, 31, 10'h2AA);
      send_request(OP_JGT, 0, 25, 0, 10'h001);
      send_request(5'd31, 0, 0, 0, 0);

      // Fill the queue to overflow while the receiver holds off.
      hold_cycles = 400;
      repeat (258) send_request(OP_PUSH_IMM, 16'($urandom()), 0, 0, 0);
      repeat (258) send_request(OP_PRINT_Q, 0, 0, 0, 0);

      // Random phases with changing idle mix.
      repeat (450) random_request();
      send_idle_pct = 73;
      recv_idle_pct = 38;
      repeat (450) random_request();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (300) random_request();
      send_request(OP_QUIT, 0, 0, 0, 0);
      repeat (10) random_request();
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/qme_pkg.sv
rtl/qme_divider.sv
rtl/qme_queue_mem.sv
rtl/queue_machine_execute.sv
tb/queue_machine_checker.sv
tb/queue_machine_execute_tb.sv
